FILE: rtl/wavetable_sound_voices_top_macros.svh
// Assertion macros shared by the wavetable sound voice block.
`ifndef WAVETABLE_SOUND_VOICES_TOP_MACROS_SVH
`define WAVETABLE_SOUND_VOICES_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define WSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/wsv_pkg.sv
// Types and constants of the wavetable sound voice block.
package wsv_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_GAIN   = 1'b1;

    localparam logic       ENABLE_RESET = 1'b1;
    localparam logic [7:0] GAIN_RESET   = 8'd48;

    localparam logic [2:0] SUB_FREQ0 = 3'd0;
    localparam logic [2:0] SUB_FREQ1 = 3'd1;
    localparam logic [2:0] SUB_FREQ2 = 3'd2;
    localparam logic [2:0] SUB_WAVE  = 3'd3;
    localparam logic [2:0] SUB_BANK  = 3'd5;
    localparam logic [2:0] SUB_VOL   = 3'd7;

    localparam logic [7:0]  END_MARK  = 8'hff;
    localparam logic [14:0] MAG_LIMIT = 15'h7fff;
    localparam logic [21:0] PROD_MAX  = 22'd3916800;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PRD   = 7'b0000010,
        S_PCALC = 7'b0000100,
        S_ROM   = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

endpackage

FILE: rtl/wsv_ram.sv
// Generic simple dual-port RAM with registered read.
module wsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/wavetable_sound_voices_top.sv
// Top level of the eight-voice nibble wavetable sound block.
//  channel  | dir | signals                               | carries
//  s stream | in  | i_s_tvalid/o_s_tready/i_s_tdata/tuser | tick, register write, ROM load
//  m stream | out | o_m_tvalid/i_m_tready/o_m_tdata       | mixed sample per tick
//  apb      | in  | psel/penable/pwrite/paddr/pwdata      | sound_enable, mix_gain
// After a tick is taken, each voice is checked in S_PRD; an active one also has its phase
// RAM entry read and updated in S_PCALC and, unless it is a banked voice not playing, the
// sample ROM read in S_ROM. S_MUL, S_SCALE and S_OUT follow (straight away if disabled).
// Reset is synchronous; the sample ROM is not cleared. Input is held off while a tick
// runs, including while it waits for the output register to free up.
module wavetable_sound_voices_top #(
    parameter int VOICES        = 8,
    parameter int ROM_ADDR_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // addr[14:0], wdata[22:15], zero[23]
    input  logic [1:0]  i_s_tuser,   // cmd[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // sample[15:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int RS = 21;
    localparam logic [21:0] RECIP = 22'((2**RS + VOICES - 1) / VOICES);
    localparam logic [21:0] SAT   = 22'(32768 * VOICES);
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    wsv_pkg::t_state r_state, n_state;

    logic       r_enable;
    logic [7:0] r_gain;

    logic [3:0] r_f0 [VOICES];
    logic [3:0] r_f1 [VOICES];
    logic [3:0] r_f2 [VOICES];
    logic [3:0] r_wave [VOICES];
    logic [3:0] r_bank [VOICES];
    logic [3:0] r_vol [VOICES];
    logic [3:0] r_trig [VOICES];
    logic [3:0] r_trig_eff [VOICES];
    logic       r_playing [VOICES];
    logic       r_pvalid [VOICES];

    logic [VW-1:0]      r_vidx;
    logic signed [10:0] r_sum;
    logic               r_lsb;
    logic               r_neg;
    logic [21:0]        r_prod;
    logic [14:0]        r_mag;
    logic               r_ovalid;
    logic [15:0]        r_odata;

    logic [14:0] in_addr;
    logic [7:0]  in_wdata;
    logic        accept;
    logic [13:0] off;
    logic        is_low, is_trig, k_ok;
    logic [2:0]  k;

    assign in_addr  = i_s_tdata[14:0];
    assign in_wdata = i_s_tdata[22:15];
    assign o_s_tready = (r_state == wsv_pkg::S_IDLE);
    assign accept   = i_s_tvalid && o_s_tready;
    assign off      = in_addr[13:0];
    assign is_low   = (off[13:6] == 8'd0);
    assign is_trig  = off[13];
    assign k        = off[5:3];
    assign k_ok     = ({1'b0, k} < 4'(VOICES));

    logic wr_low, wr_trig;
    assign wr_low  = accept && (i_s_tuser == wsv_pkg::CMD_WRITE) && is_low;
    assign wr_trig = accept && (i_s_tuser == wsv_pkg::CMD_WRITE) && is_trig;

    // current voice parameters
    logic [3:0]  cur_vol, cur_bank;
    logic [11:0] cur_freq;
    logic [14:0] cur_base;
    logic        cur_active;
    assign cur_vol    = r_vol[r_vidx];
    assign cur_bank   = r_bank[r_vidx];
    assign cur_freq   = {r_f2[r_vidx], r_f1[r_vidx], r_f0[r_vidx]};
    assign cur_active = (cur_vol != 4'd0) && (cur_freq != 12'd0);
    assign cur_base   = (cur_bank != 4'd0) ? {cur_bank, r_trig_eff[r_vidx], 7'd0}
                                           : {7'd0, r_wave[r_vidx], 4'd0};

    // phase RAM
    logic [31:0] ph_rdata, ph_cur, ph_next, ph_wdata;
    logic        ph_we;
    logic [VW-1:0] ph_waddr;
    assign ph_cur  = r_pvalid[r_vidx] ? ph_rdata : 32'd0;
    assign ph_next = ph_cur + {16'd0, cur_freq, 4'd0};

    always_comb begin
        ph_we    = 1'b0;
        ph_waddr = r_vidx;
        ph_wdata = ph_next;
        if (r_state == wsv_pkg::S_PCALC) begin
            ph_we = 1'b1;
        end else if (wr_trig && k_ok && (r_bank[k[VW-1:0]] != 4'd0)) begin
            ph_we    = 1'b1;
            ph_waddr = k[VW-1:0];
            ph_wdata = 32'd0;
        end
    end

    wsv_ram #(.WIDTH(32), .DEPTH(VOICES)) u_phase (
        .i_clk   (i_clk),
        .i_we    (ph_we),
        .i_waddr (ph_waddr),
        .i_wdata (ph_wdata),
        .i_raddr (r_vidx),
        .o_rdata (ph_rdata)
    );

    // sample ROM
    logic [15:0] byte_off;
    logic [16:0] rom_sum;
    logic [15:0] load_addr;
    logic [ROM_ADDR_BITS-1:0] rom_raddr;
    logic [7:0] rom_rdata;
    assign byte_off  = (cur_bank != 4'd0) ? ph_next[31:16] : {12'd0, ph_next[19:16]};
    assign rom_sum   = {2'd0, cur_base} + {1'b0, byte_off};
    assign rom_raddr = rom_sum[ROM_ADDR_BITS-1:0];
    assign load_addr = {1'b0, in_addr};

    wsv_ram #(.WIDTH(8), .DEPTH(2**ROM_ADDR_BITS)) u_rom (
        .i_clk   (i_clk),
        .i_we    (accept && (i_s_tuser == wsv_pkg::CMD_LOAD)),
        .i_waddr (load_addr[ROM_ADDR_BITS-1:0]),
        .i_wdata (in_wdata),
        .i_raddr (rom_raddr),
        .o_rdata (rom_rdata)
    );

    // nibble contribution
    logic [3:0]         nib;
    logic signed [4:0]  nib_s;
    logic signed [9:0]  contrib;
    assign nib     = r_lsb ? rom_rdata[3:0] : rom_rdata[7:4];
    assign nib_s   = $signed({1'b0, nib}) - 5'sd8;
    assign contrib = nib_s * $signed({1'b0, cur_vol});

    // scaling
    logic [9:0]  abs_sum;
    logic [39:0] quot_full;
    assign abs_sum   = r_sum[10] ? 10'(-r_sum) : r_sum[9:0];
    assign quot_full = {22'd0, r_prod[17:0]} * {18'd0, RECIP};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wsv_pkg::S_IDLE: begin
                if (accept && (i_s_tuser == wsv_pkg::CMD_TICK)) begin
                    n_state = r_enable ? wsv_pkg::S_PRD : wsv_pkg::S_MUL;
                end
            end
            wsv_pkg::S_PRD: begin
                if (cur_active) begin
                    n_state = wsv_pkg::S_PCALC;
                end else if (r_vidx == LAST_VOICE) begin
                    n_state = wsv_pkg::S_MUL;
                end
            end
            wsv_pkg::S_PCALC: begin
                if ((cur_bank != 4'd0) && !r_playing[r_vidx]) begin
                    n_state = (r_vidx == LAST_VOICE) ? wsv_pkg::S_MUL : wsv_pkg::S_PRD;
                end else begin
                    n_state = wsv_pkg::S_ROM;
                end
            end
            wsv_pkg::S_ROM: begin
                n_state = (r_vidx == LAST_VOICE) ? wsv_pkg::S_MUL : wsv_pkg::S_PRD;
            end
            wsv_pkg::S_MUL:   n_state = wsv_pkg::S_SCALE;
            wsv_pkg::S_SCALE: n_state = wsv_pkg::S_OUT;
            wsv_pkg::S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_state = wsv_pkg::S_IDLE;
                end
            end
            default: n_state = wsv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wsv_pkg::S_IDLE;
            r_enable <= wsv_pkg::ENABLE_RESET;
            r_gain   <= wsv_pkg::GAIN_RESET;
            r_ovalid <= 1'b0;
            r_vidx   <= '0;
            for (int v = 0; v < VOICES; v++) begin
                r_f0[v]       <= 4'd0;
                r_f1[v]       <= 4'd0;
                r_f2[v]       <= 4'd0;
                r_wave[v]     <= 4'd0;
                r_bank[v]     <= 4'd0;
                r_vol[v]      <= 4'd0;
                r_trig[v]     <= 4'd0;
                r_trig_eff[v] <= 4'd0;
                r_playing[v]  <= 1'b0;
                r_pvalid[v]   <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == wsv_pkg::REG_ENABLE) begin
                    r_enable <= pwdata[0];
                end else begin
                    r_gain <= pwdata[7:0];
                end
            end
            if (ph_we) begin
                r_pvalid[ph_waddr] <= 1'b1;
            end
            if (wr_low) begin
                for (int v = 0; v < VOICES; v++) begin
                    r_trig_eff[v] <= r_trig[v];
                    if ((k == 3'(v)) && (off[2:0] == wsv_pkg::SUB_BANK)) begin
                        if (in_wdata[3:0] == 4'd0) begin
                            r_playing[v] <= 1'b0;
                        end
                    end else if (r_bank[v] == 4'd0) begin
                        r_playing[v] <= 1'b0;
                    end
                end
                if (k_ok) begin
                    unique case (off[2:0])
                        wsv_pkg::SUB_FREQ0: r_f0[k[VW-1:0]]   <= in_wdata[3:0];
                        wsv_pkg::SUB_FREQ1: r_f1[k[VW-1:0]]   <= in_wdata[3:0];
                        wsv_pkg::SUB_FREQ2: r_f2[k[VW-1:0]]   <= in_wdata[3:0];
                        wsv_pkg::SUB_WAVE:  r_wave[k[VW-1:0]] <= in_wdata[3:0];
                        wsv_pkg::SUB_BANK:  r_bank[k[VW-1:0]] <= in_wdata[3:0];
                        wsv_pkg::SUB_VOL:   r_vol[k[VW-1:0]]  <= in_wdata[3:0];
                        default: ;
                    endcase
                end
            end
            if (wr_trig && k_ok) begin
                if ((off[12:6] == 7'd0) && (off[2:0] == wsv_pkg::SUB_BANK)) begin
                    r_trig[k[VW-1:0]] <= in_wdata[3:0];
                end
                if (r_bank[k[VW-1:0]] != 4'd0) begin
                    r_playing[k[VW-1:0]] <= 1'b1;
                end
            end
            if (accept) begin
                r_vidx <= '0;
            end else if (((r_state == wsv_pkg::S_PRD) && !cur_active) ||
                         (r_state == wsv_pkg::S_ROM) ||
                         ((r_state == wsv_pkg::S_PCALC) && (n_state == wsv_pkg::S_PRD))) begin
                if (r_vidx != LAST_VOICE) begin
                    r_vidx <= r_vidx + VW'(1);
                end
            end
            if ((r_state == wsv_pkg::S_ROM) && (cur_bank != 4'd0) &&
                (rom_rdata == wsv_pkg::END_MARK)) begin
                r_playing[r_vidx] <= 1'b0;
            end
            if (r_state == wsv_pkg::S_OUT && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum <= '0;
        end else if ((r_state == wsv_pkg::S_ROM) &&
                     !((cur_bank != 4'd0) && (rom_rdata == wsv_pkg::END_MARK))) begin
            r_sum <= r_sum + 11'(contrib);
        end
        if (r_state == wsv_pkg::S_PCALC) begin
            r_lsb <= ph_next[15];
        end
        if (r_state == wsv_pkg::S_MUL) begin
            r_neg  <= r_sum[10];
            r_prod <= {({8'd0, abs_sum} * {10'd0, r_gain}), 4'd0};
        end
        if (r_state == wsv_pkg::S_SCALE) begin
            r_mag <= (r_prod >= SAT) ? wsv_pkg::MAG_LIMIT : quot_full[RS+14:RS];
        end
        if (r_state == wsv_pkg::S_OUT && (!r_ovalid || i_m_tready)) begin
            r_odata <= r_neg ? 16'(-{1'b0, r_mag}) : {1'b0, r_mag};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == wsv_pkg::REG_GAIN) ? {24'd0, r_gain} : {31'd0, r_enable};

`include "wavetable_sound_voices_top_macros.svh"

    `WSV_ASSERT_NEXT(a_out_load, (r_state == wsv_pkg::S_OUT) && (!r_ovalid || i_m_tready), o_m_tvalid && (r_state == wsv_pkg::S_IDLE))
    `WSV_ASSERT_NEXT(a_mute_tick, accept && (i_s_tuser == wsv_pkg::CMD_TICK) && !r_enable, (r_state == wsv_pkg::S_MUL) && (r_sum == 11'sd0))
    `WSV_ASSERT_IMPL(a_prod_range, r_state == wsv_pkg::S_SCALE, r_prod <= wsv_pkg::PROD_MAX)

endmodule
